// ===== rtl/mcfe_pkg.sv =====
// Shared types, limit tables and helper functions for the motor command frame encoder.
package mcfe_pkg;

  // Default configuration
  localparam int FRAC_BITS_DEF = 16;
  localparam int CODE_MAX_DEF  = 65535;

  // Largest limit in hundredths (kp of the big models), sets the limit width
  localparam int unsigned LIM_HUND_MAX = 500000;
  localparam int unsigned ANGLE_HUND   = 1257;

  // Number of encoding lanes and their order
  localparam int NUM_LANES  = 5;
  localparam int LANE_ANGLE = 0;
  localparam int LANE_SPEED = 1;
  localparam int LANE_TORQ  = 2;
  localparam int LANE_KP    = 3;
  localparam int LANE_KD    = 4;

  localparam int NUM_MODELS = 8;
  localparam logic [4:0] MODE_RESET = 5'd1;

  typedef struct packed {
    logic        [2:0]  motor_model;
    logic        [7:0]  node_id;
    logic signed [31:0] target_angle;
    logic signed [31:0] target_speed;
    logic signed [31:0] target_torque;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
  } mcfe_cmd_t;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [63:0] frame_payload;
  } mcfe_frame_t;

  // Upper limit of one lane for one motor model, in hundredths
  function automatic int unsigned lim_hund(input int model, input int lane);
    int unsigned spd;
    int unsigned trq;
    int unsigned kp;
    int unsigned kd;
    unique case (model)
      0:       begin spd = 3300; trq = 1400;  kp = 50000;  kd = 500;   end
      1:       begin spd = 4400; trq = 1700;  kp = 50000;  kd = 500;   end
      2:       begin spd = 4400; trq = 1700;  kp = 50000;  kd = 500;   end
      3:       begin spd = 2000; trq = 6000;  kp = 500000; kd = 10000; end
      4:       begin spd = 1500; trq = 12000; kp = 500000; kd = 10000; end
      5:       begin spd = 5000; trq = 550;   kp = 50000;  kd = 500;   end
      6:       begin spd = 5000; trq = 3600;  kp = 500000; kd = 10000; end
      default: begin spd = 5000; trq = 600;   kp = 50000;  kd = 500;   end
    endcase
    unique case (lane)
      LANE_ANGLE: return ANGLE_HUND;
      LANE_SPEED: return spd;
      LANE_TORQ:  return trq;
      LANE_KP:    return kp;
      default:    return kd;
    endcase
  endfunction

  // Round a limit in hundredths to nearest at frac fractional bits
  function automatic longint unsigned to_fixed(input int unsigned hund, input int frac);
    longint unsigned scaled;
    scaled = longint'(hund) << frac;
    return (scaled + 64'd50) / 64'd100;
  endfunction

  // Pipeline depth of one lane: clamp, offset, multiply, one stage per quotient bit
  function automatic int lane_depth(input int code_max);
    return 3 + $clog2(code_max + 1);
  endfunction

endpackage

// ===== rtl/mcfe_lane.sv =====
// One encoding lane: clamp to the limit, offset, scale by the code range, divide by the span.
module mcfe_lane import mcfe_pkg::*; #(
  parameter int LIM_W    = 29,
  parameter int CODE_MAX = CODE_MAX_DEF,
  parameter bit SYM      = 1'b1
) (
  input  logic                clk,
  input  logic                adv,
  input  logic signed [31:0]  x,
  input  logic [LIM_W-1:0]    lim,
  output logic [15:0]         code
);

  localparam int SPAN_W = LIM_W + 1;
  localparam int XW     = ((LIM_W > 32) ? LIM_W : 32) + 2;
  localparam int CODE_W = $clog2(CODE_MAX + 1);
  localparam int PROD_W = SPAN_W + CODE_W;

  // Stage 0: clamp to [lo, hi]
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] hi;
  logic signed [XW-1:0] lo;
  logic signed [XW-1:0] xc;
  logic [SPAN_W-1:0]    span_in;

  assign x_ext   = {{(XW-32){x[31]}}, x};
  assign hi      = {{(XW-LIM_W){1'b0}}, lim};
  assign lo      = SYM ? -hi : '0;
  assign span_in = SYM ? {lim, 1'b0} : {1'b0, lim};

  always_comb begin
    priority if (x_ext > hi) xc = hi;
    else if (x_ext < lo)     xc = lo;
    else                     xc = x_ext;
  end

  logic signed [XW-1:0] xc_r;
  logic signed [XW-1:0] lo_r;
  logic [SPAN_W-1:0]    span0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xc_r    <= xc;
      lo_r    <= lo;
      span0_r <= span_in;
    end
  end

  // Stage 1: offset from the low end, lies in 0..span
  logic [SPAN_W-1:0] off_r;
  logic [SPAN_W-1:0] span1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      off_r   <= SPAN_W'(xc_r - lo_r);
      span1_r <= span0_r;
    end
  end

  // Stage 2: scale by the code range
  logic [PROD_W-1:0] prod_r;
  logic [SPAN_W-1:0] span2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= PROD_W'(off_r) * PROD_W'(CODE_MAX);
      span2_r <= span1_r;
    end
  end

  // Division stages: one quotient bit per stage, restoring
  logic [SPAN_W-1:0] rem_r  [CODE_W-1];
  logic [CODE_W-1:0] low_r  [CODE_W-1];
  logic [SPAN_W-1:0] dspan_r[CODE_W-1];
  logic [CODE_W-1:0] quo_r  [CODE_W];

  genvar j;
  generate
    for (j = 0; j < CODE_W; j++) begin : g_div
      logic [SPAN_W-1:0] rem_i;
      logic [CODE_W-1:0] low_i;
      logic [CODE_W-1:0] quo_i;
      logic [SPAN_W-1:0] span_i;
      logic [SPAN_W:0]   trial;
      logic              ge;

      if (j == 0) begin : g_first
        assign rem_i  = prod_r[PROD_W-1:CODE_W];
        assign low_i  = prod_r[CODE_W-1:0];
        assign quo_i  = '0;
        assign span_i = span2_r;
      end else begin : g_next
        assign rem_i  = rem_r[j-1];
        assign low_i  = low_r[j-1];
        assign quo_i  = quo_r[j-1];
        assign span_i = dspan_r[j-1];
      end

      assign trial = {rem_i, low_i[CODE_W-1]};
      assign ge    = (trial >= {1'b0, span_i});

      always_ff @(posedge clk) begin
        if (adv) begin
          quo_r[j] <= {quo_i[CODE_W-2:0], ge};
        end
      end

      if (j < CODE_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_r[j]   <= ge ? SPAN_W'(trial - {1'b0, span_i}) : SPAN_W'(trial);
            low_r[j]   <= low_i << 1;
            dspan_r[j] <= span_i;
          end
        end
      end
    end
  endgenerate

  assign code = 16'(quo_r[CODE_W-1]);

endmodule

// ===== rtl/motor_command_frame_encoder.sv =====
// Top level of the motor command frame encoder: limit table, lane pipelines, framing.
//
// Packs one motor impedance command into a 29-bit extended frame id and an 8-byte
// payload. Every target is clamped to the limits of the selected motor model and
// mapped to 0..CODE_MAX by truncating (x - min) * CODE_MAX / (max - min). One command
// is accepted every clock cycle unless the output stalls; the divider resolves one
// code bit per pipeline stage. A stall on the output while a result is waiting
// freezes the whole pipeline and is passed straight back to in_stall. The mode code
// register resets to 1 and is written through the cfg port, which is always ready;
// write it only while no request is in flight.
module motor_command_frame_encoder import mcfe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CODE_MAX  = CODE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mcfe_cmd_t   in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output mcfe_frame_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int LIM_W = $clog2(to_fixed(LIM_HUND_MAX, FRAC_BITS) + 1);
  localparam int DEPTH = lane_depth(CODE_MAX);

  // Mode code register
  logic [4:0] mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Limit table, rounded at elaboration
  logic [LIM_W-1:0] lim_tab [NUM_MODELS][NUM_LANES];

  genvar m, k;
  generate
    for (m = 0; m < NUM_MODELS; m++) begin : g_model
      for (k = 0; k < NUM_LANES; k++) begin : g_kind
        localparam logic [LIM_W-1:0] LIM = LIM_W'(to_fixed(lim_hund(m, k), FRAC_BITS));
        assign lim_tab[m][k] = LIM;
      end
    end
  endgenerate

  // Advance the pipeline unless the finished request is held
  logic             adv;
  logic [DEPTH-1:0] v_r;
  logic [7:0]       id_r [DEPTH];

  assign adv      = !(v_r[DEPTH-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  // Carry the node id alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      id_r[0] <= in_data.node_id;
      for (int i = 1; i < DEPTH; i++) begin
        id_r[i] <= id_r[i-1];
      end
    end
  end

  // Encoding lanes
  logic signed [31:0] lane_x    [NUM_LANES];
  logic [15:0]        lane_code [NUM_LANES];

  assign lane_x[LANE_ANGLE] = in_data.target_angle;
  assign lane_x[LANE_SPEED] = in_data.target_speed;
  assign lane_x[LANE_TORQ]  = in_data.target_torque;
  assign lane_x[LANE_KP]    = in_data.stiffness_gain;
  assign lane_x[LANE_KD]    = in_data.damping_gain;

  generate
    for (k = 0; k < NUM_LANES; k++) begin : g_lane
      mcfe_lane #(
        .LIM_W    (LIM_W),
        .CODE_MAX (CODE_MAX),
        .SYM      (k < LANE_KP)
      ) u_lane (
        .clk  (clk),
        .adv  (adv),
        .x    (lane_x[k]),
        .lim  (lim_tab[in_data.motor_model][k]),
        .code (lane_code[k])
      );
    end
  endgenerate

  // Assemble the frame
  assign out_valid              = v_r[DEPTH-1];
  assign out_data.frame_id      = {mode_r, lane_code[LANE_TORQ], id_r[DEPTH-1]};
  assign out_data.frame_payload = {lane_code[LANE_ANGLE], lane_code[LANE_SPEED],
                                   lane_code[LANE_KP], lane_code[LANE_KD]};

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved during a stall");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (mode_r == $past(cfg_data)))
    else $error("mode code write lost");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_payload[63:48] <= 16'(CODE_MAX)) &&
                  (out_data.frame_id[23:8] <= 16'(CODE_MAX)))
    else $error("code above the code range");

endmodule
